/* src/udprc_pkg.sv */
`timescale 1ns / 1ps

package udprc_pkg;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_PORT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISCARD_PORT = 2'd1;

    localparam logic [15:0] ECHO_PORT_RST    = 16'd7;
    localparam logic [15:0] DISCARD_PORT_RST = 16'd9;

    localparam logic [18:0] UDP_PROTO  = 19'd17;
    localparam logic [15:0] HEADER_LEN = 16'd8;
    localparam logic [15:0] POS_MAX    = 16'hffff;
    localparam logic [15:0] HI_BYTE    = 16'hff00;

    typedef enum logic [1:0] {
        VERDICT_DELIVER  = 2'd0,
        VERDICT_ECHO     = 2'd1,
        VERDICT_DISCARD  = 2'd2,
        VERDICT_CSUM_ERR = 2'd3
    } t_verdict;

    typedef struct packed {
        logic [15:0] echo_port;
        logic [15:0] discard_port;
    } t_cfg;

    typedef struct packed {
        logic [31:0] running_sum;
        logic [18:0] pseudo_sum;
        logic [15:0] udp_length;
        logic [15:0] rx_checksum;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic        truncated;
    } t_seg_rec;

endpackage

/* src/udprc_intf.sv */
`timescale 1ns / 1ps

interface udprc_seg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  seg_byte;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic        last_byte;

    modport source (output valid, seg_byte, source_ip, dest_ip, last_byte, input ready);
    modport sink (input valid, seg_byte, source_ip, dest_ip, last_byte, output ready);
endinterface

interface udprc_res_if import udprc_pkg::*; ();
    logic        valid;
    logic        ready;
    t_verdict    verdict;
    logic [15:0] computed_sum;
    logic [15:0] udp_length;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic        truncated;

    modport source (output valid, verdict, computed_sum, udp_length, source_port, dest_port,
                    truncated, input ready);
    modport sink (input valid, verdict, computed_sum, udp_length, source_port, dest_port,
                  truncated, output ready);
endinterface

interface udprc_cfg_if import udprc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [15:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* src/udprc_front.sv */
`timescale 1ns / 1ps

module udprc_front import udprc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    udprc_seg_if.sink     i_seg,
    input  logic          i_queue_full,
    output logic          o_push,
    output t_seg_rec      o_rec
);

    logic [15:0] r_pos, n_pos;
    logic [7:0]  r_hold, n_hold;
    logic [15:0] r_len, n_len;
    logic [15:0] r_rx, n_rx;
    logic [15:0] r_sp, n_sp;
    logic [15:0] r_dp, n_dp;
    logic [31:0] r_running, n_running;
    logic [18:0] r_pseudo, n_pseudo;
    logic        pos0;
    logic        accept;
    logic [15:0] word;

    assign i_seg.ready = !i_queue_full;
    assign accept      = i_seg.valid && i_seg.ready;
    assign pos0        = (r_pos == 16'd0);
    assign word        = {r_hold, i_seg.seg_byte};

    always_comb begin
        n_hold    = pos0 ? 8'd0  : r_hold;
        n_len     = pos0 ? 16'd0 : r_len;
        n_rx      = pos0 ? 16'd0 : r_rx;
        n_sp      = pos0 ? 16'd0 : r_sp;
        n_dp      = pos0 ? 16'd0 : r_dp;
        n_running = pos0 ? 32'd0 : r_running;
        n_pseudo  = r_pseudo;
        if (pos0) begin
            n_pseudo = {3'b000, i_seg.source_ip[31:16]} + {3'b000, i_seg.source_ip[15:0]}
                     + {3'b000, i_seg.dest_ip[31:16]} + {3'b000, i_seg.dest_ip[15:0]}
                     + UDP_PROTO;
        end
        if (r_pos < HEADER_LEN) begin
            if (!r_pos[0]) begin
                n_hold = i_seg.seg_byte;
            end else begin
                case (r_pos[2:1])
                    2'd0:    n_sp = word;
                    2'd1:    n_dp = word;
                    2'd2:    n_len = word;
                    default: n_rx = word;
                endcase
            end
        end else if (r_pos < r_len) begin
            if (r_pos[0]) begin
                n_running = r_running + {24'd0, i_seg.seg_byte};
            end else begin
                n_running = r_running + {16'd0, i_seg.seg_byte, 8'd0};
            end
        end
        n_pos = (r_pos == POS_MAX) ? r_pos : r_pos + 16'd1;
    end

    assign o_push = accept && i_seg.last_byte;

    always_comb begin
        o_rec.running_sum = n_running;
        o_rec.pseudo_sum  = n_pseudo;
        o_rec.udp_length  = n_len;
        o_rec.rx_checksum = n_rx;
        o_rec.source_port = n_sp;
        o_rec.dest_port   = n_dp;
        o_rec.truncated   = (({1'b0, r_pos} + 17'd1) < {1'b0, n_len});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_pos     <= '0;
            r_hold    <= '0;
            r_len     <= '0;
            r_rx      <= '0;
            r_sp      <= '0;
            r_dp      <= '0;
            r_running <= '0;
            r_pseudo  <= '0;
        end else if (accept) begin
            r_pos     <= n_pos;
            r_hold    <= n_hold;
            r_len     <= n_len;
            r_rx      <= n_rx;
            r_sp      <= n_sp;
            r_dp      <= n_dp;
            r_running <= n_running;
            r_pseudo  <= n_pseudo;
        end
    end

endmodule

/* src/udprc_queue.sv */
`timescale 1ns / 1ps

module udprc_queue import udprc_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_seg_rec i_rec,
    input  logic     i_pop,
    output logic     o_full,
    output logic     o_valid,
    output t_seg_rec o_rec
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_seg_rec         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* src/udprc_back.sv */
`timescale 1ns / 1ps

module udprc_back import udprc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    input  t_seg_rec    i_rec,
    output logic        o_pop,
    udprc_res_if.source o_res
);

    logic        r_v1, r_v2, r_vo;
    logic        adv1, adv2, advo;

    logic [31:0] r1_running;
    logic [19:0] r1_hdr;
    logic [15:0] r1_len, r1_rx, r1_sp, r1_dp;
    logic        r1_trunc;

    logic [31:0] r2_sum;
    logic [15:0] r2_len, r2_rx, r2_sp, r2_dp;
    logic        r2_trunc;

    logic [15:0] hw0, hw1, hw2;
    logic [19:0] n_hdr;
    logic [16:0] fold1;
    logic [15:0] fold2, computed;
    logic        csum_ok;
    t_verdict    n_verdict;

    t_verdict    r_verdict;
    logic [15:0] r_computed, r_len_o, r_sp_o, r_dp_o;
    logic        r_trunc_o;

    assign advo  = !r_vo || o_res.ready;
    assign adv2  = !r_v2 || advo;
    assign adv1  = !r_v1 || adv2;
    assign o_pop = i_valid && adv1;

    // Header words count only for the bytes that lie below the length field.
    always_comb begin
        hw0 = (i_rec.udp_length > 16'd1) ? i_rec.source_port :
              (i_rec.udp_length > 16'd0) ? (i_rec.source_port & HI_BYTE) : 16'd0;
        hw1 = (i_rec.udp_length > 16'd3) ? i_rec.dest_port :
              (i_rec.udp_length > 16'd2) ? (i_rec.dest_port & HI_BYTE) : 16'd0;
        hw2 = (i_rec.udp_length > 16'd5) ? i_rec.udp_length :
              (i_rec.udp_length > 16'd4) ? (i_rec.udp_length & HI_BYTE) : 16'd0;
        n_hdr = {1'b0, i_rec.pseudo_sum} + {4'd0, i_rec.udp_length}
              + {4'd0, hw0} + {4'd0, hw1} + {4'd0, hw2};
    end

    always_comb begin
        fold1    = {1'b0, r2_sum[15:0]} + {1'b0, r2_sum[31:16]};
        fold2    = fold1[15:0] + {15'd0, fold1[16]};
        computed = ~fold2;
        csum_ok  = (r2_rx == 16'd0) || (r2_rx == computed)
                || ((r2_rx == 16'hffff) && (computed == 16'd0));
        if (!csum_ok) begin
            n_verdict = VERDICT_CSUM_ERR;
        end else if (r2_dp == i_cfg.echo_port) begin
            n_verdict = VERDICT_ECHO;
        end else if (r2_dp == i_cfg.discard_port) begin
            n_verdict = VERDICT_DISCARD;
        end else begin
            n_verdict = VERDICT_DELIVER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (advo) begin
                r_vo <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r1_running <= i_rec.running_sum;
            r1_hdr     <= n_hdr;
            r1_len     <= i_rec.udp_length;
            r1_rx      <= i_rec.rx_checksum;
            r1_sp      <= i_rec.source_port;
            r1_dp      <= i_rec.dest_port;
            r1_trunc   <= i_rec.truncated;
        end
        if (adv2) begin
            r2_sum   <= r1_running + {12'd0, r1_hdr};
            r2_len   <= r1_len;
            r2_rx    <= r1_rx;
            r2_sp    <= r1_sp;
            r2_dp    <= r1_dp;
            r2_trunc <= r1_trunc;
        end
        if (advo) begin
            r_verdict  <= n_verdict;
            r_computed <= computed;
            r_len_o    <= r2_len;
            r_sp_o     <= r2_sp;
            r_dp_o     <= r2_dp;
            r_trunc_o  <= r2_trunc;
        end
    end

    assign o_res.valid        = r_vo;
    assign o_res.verdict      = r_verdict;
    assign o_res.computed_sum = r_computed;
    assign o_res.udp_length   = r_len_o;
    assign o_res.source_port  = r_sp_o;
    assign o_res.dest_port    = r_dp_o;
    assign o_res.truncated    = r_trunc_o;

endmodule

/* src/udp_receive_checksum_classifier_top.sv */
`timescale 1ns / 1ps
// Accepts one segment byte per cycle while the queue is not full, with no gaps between segments.
// Each record is queued, then passes r1, r2 and the output stage; one result per cycle while ready is high.
// Rate is set by the single add into the running sum; the check runs in a 3-stage back pipeline.
// Reset is synchronous and active low: it clears segment state, queue and pipeline,
// and sets the echo port to 7 and the discard port to 9.

module udp_receive_checksum_classifier_top import udprc_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    udprc_seg_if.sink   i_seg,
    udprc_cfg_if.sink   i_cfg,
    udprc_res_if.source o_res
);

    t_cfg     r_cfg;
    logic     push, pop, q_full, q_valid;
    t_seg_rec front_rec, head_rec;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.echo_port    <= ECHO_PORT_RST;
            r_cfg.discard_port <= DISCARD_PORT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_ECHO_PORT:    r_cfg.echo_port <= i_cfg.data;
                REG_DISCARD_PORT: r_cfg.discard_port <= i_cfg.data;
                default:          ;
            endcase
        end
    end

    udprc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seg        (i_seg),
        .i_queue_full (q_full),
        .o_push       (push),
        .o_rec        (front_rec)
    );

    udprc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rec   (head_rec)
    );

    udprc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .i_rec   (head_rec),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

/* src/udprc_checker.sv */
`timescale 1ns / 1ps

module udprc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [1:0]  i_verdict,
    input logic [15:0] i_computed_sum,
    input logic [15:0] i_udp_length,
    input logic        i_truncated
);

    // The folded sum always includes the protocol number, so it is never zero.
    a_sum_never_ones : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_computed_sum != 16'hffff))
        else $error("computed checksum shows a folded sum of zero");

    // At least one byte is received, so truncation needs a length above one.
    a_trunc_length : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_truncated) |-> (i_udp_length > 16'd1))
        else $error("truncated flagged for a length that one byte satisfies");

    a_no_result_after_reset : assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    a_valid_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> i_res_valid)
        else $error("result dropped before transfer");

    a_payload_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
            ($stable(i_verdict) && $stable(i_computed_sum) && $stable(i_udp_length)
             && $stable(i_truncated)))
        else $error("stalled result changed");

endmodule

bind udp_receive_checksum_classifier_top udprc_checker u_udprc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_verdict      (o_res.verdict),
    .i_computed_sum (o_res.computed_sum),
    .i_udp_length   (o_res.udp_length),
    .i_truncated    (o_res.truncated)
);
